### rtl/pfa_pkg.sv
// Package for the page frame allocator: opcodes, status codes, states,
// request, result and configuration word types. No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

    // Request opcodes.
    typedef enum logic [2:0] {
        OP_MARK_RANGE = 3'd0,
        OP_ALLOC_ONE  = 3'd1,
        OP_ALLOC_RUN  = 3'd2,
        OP_FREE       = 3'd3,
        OP_ADJUST     = 3'd4,
        OP_SHARE      = 3'd5,
        OP_FREE_OWNER = 3'd6,
        OP_NONE       = 3'd7
    } pfa_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NO_FRAME  = 2'd2,
        ST_BAD_OWNER = 2'd3
    } pfa_status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_RUN_WRITE,
        S_FINISH
    } pfa_state_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAGES_IN_USE = 2'd0;
    localparam logic [1:0] CFG_LOWEST_OWNER = 2'd1;
    localparam logic [1:0] CFG_FREE_MARK    = 2'd2;

    // Owner ids written by a plain free and by the reset clearing pass.
    localparam logic [15:0] OWNER_FREED = 16'hFFFE;
    localparam logic [15:0] OWNER_RESET = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] owner_id;
        logic [15:0]        page_number;
        logic [16:0]        range_end;
        logic [16:0]        run_length;
        logic signed [7:0]  share_adjust;
    } pfa_cmd_t;

    typedef struct packed {
        logic [15:0] frame_out;
        logic [1:0]  status;
        logic [16:0] free_frames;
    } pfa_res_t;

    typedef struct packed {
        logic [16:0]        pages_in_use;
        logic signed [15:0] lowest_valid_owner;
        logic signed [15:0] free_owner_mark;
    } pfa_cfg_t;

    // Frame table port controls.
    typedef struct packed {
        logic rd;
        logic wr;
    } pfa_mem_ctl_t;

endpackage

### rtl/pfa_table.sv
// Frame table memory: one word per frame with available flag, sharing
// counter and owner id. Single port, registered read. Uses pfa_pkg.
`timescale 1ns / 1ps

module pfa_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 25
) (
    input  logic                  clk,
    input  pfa_pkg::pfa_mem_ctl_t ctl,
    input  logic [AW-1:0]         addr,
    input  logic [DW-1:0]         wdata,
    output logic [DW-1:0]         rdata
);
    import pfa_pkg::*;

    logic [DW-1:0] mem [DEPTH];

    // Write and registered read share one address.
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### rtl/pfa_seq.sv
// Request sequencer: walks the frame table one entry per step through a
// shared read-check-write unit. Uses pfa_pkg and drives pfa_table.
`timescale 1ns / 1ps

module pfa_seq #(
    parameter int MAX_FRAMES   = 1024,
    parameter int COUNTER_BITS = 8,
    parameter int AW           = 10,
    parameter int DW           = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  pfa_pkg::pfa_cmd_t     cmd,
    input  pfa_pkg::pfa_cfg_t     cfg,
    output logic                  busy,
    output logic                  done,
    output pfa_pkg::pfa_res_t     result,
    output pfa_pkg::pfa_mem_ctl_t mem_ctl,
    output logic [AW-1:0]         mem_addr,
    output logic [DW-1:0]         mem_wdata,
    input  logic [DW-1:0]         mem_rdata
);
    import pfa_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int VW = CB + 10;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
    localparam logic [16:0] DEPTH17 = 17'(MAX_FRAMES);
    localparam logic [16:0] LAST17  = 17'(MAX_FRAMES - 1);

    pfa_state_t  state_reg, state_next;
    pfa_cmd_t    cmd_reg, cmd_next;
    logic [16:0] idx_reg, idx_next;
    logic [16:0] scan_reg, scan_next;
    logic [16:0] end_reg, end_next;
    logic [16:0] n_reg, n_next;
    logic [16:0] limit_reg, limit_next;
    logic [15:0] frame_reg, frame_next;
    logic [1:0]  status_reg, status_next;
    logic [16:0] free_reg, free_next;
    logic [15:0] cursor_reg, cursor_next;

    logic [16:0] n_now, lim_now, idx_inc, scan_inc, start_idx;
    logic        owner_bad;
    logic        rd_avail;
    logic [CB-1:0] rd_cnt;
    logic [15:0] rd_owner;
    logic        can_take;
    logic signed [VW-1:0] adj_amt, adj_sum;
    logic        adj_release;
    logic [CB-1:0] adj_cnt;
    logic [16:0] free_dec;

    // Fields of the word just read.
    assign rd_avail = mem_rdata[DW-1];
    assign rd_cnt   = mem_rdata[DW-2 -: CB];
    assign rd_owner = mem_rdata[15:0];
    assign can_take = rd_avail && (rd_cnt == '0);

    // Frames managed and the clipped end of a marked range.
    assign n_now   = (cfg.pages_in_use < DEPTH17) ? cfg.pages_in_use : DEPTH17;
    assign lim_now = (cmd.range_end < n_now) ? cmd.range_end : n_now;
    assign start_idx = ({1'b0, cursor_reg} < n_now) ? {1'b0, cursor_reg} : 17'd0;
    assign owner_bad = cmd.owner_id < cfg.lowest_valid_owner;

    assign idx_inc  = idx_reg + 17'd1;
    assign scan_inc = scan_reg + 17'd1;
    assign free_dec = (free_reg != 17'd0) ? free_reg - 17'd1 : free_reg;

    // Shared counter adder: a free of a shared frame adds minus one.
    assign adj_amt = (pfa_op_t'(cmd_reg.opcode) == OP_FREE)
                   ? -VW'(1) : VW'(cmd_reg.share_adjust);
    assign adj_sum = $signed({{(VW-CB){1'b0}}, rd_cnt}) + adj_amt;
    assign adj_release = adj_sum[VW-1] || (adj_sum == '0);
    assign adj_cnt = (adj_sum > $signed({{(VW-CB){1'b0}}, CNT_MAX}))
                   ? CNT_MAX : adj_sum[CB-1:0];

    // State and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            free_reg   <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            free_reg   <= free_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        scan_reg   <= scan_next;
        end_reg    <= end_next;
        n_reg      <= n_next;
        limit_reg  <= limit_next;
        frame_reg  <= frame_next;
        status_reg <= status_next;
    end

    // Sequencer next state and table accesses.
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        scan_next   = scan_reg;
        end_next    = end_reg;
        n_next      = n_reg;
        limit_next  = limit_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        free_next   = free_reg;
        cursor_next = cursor_reg;
        mem_ctl     = '0;
        mem_wdata   = mem_rdata;

        case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr = 1'b1;
                mem_wdata  = {1'b0, {CB{1'b0}}, OWNER_RESET};
                idx_next   = idx_inc;
                if (idx_reg == LAST17)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    n_next      = n_now;
                    limit_next  = lim_now;
                    frame_next  = '0;
                    status_next = ST_OK;
                    scan_next   = '0;
                    state_next  = S_READ;
                    case (pfa_op_t'(cmd.opcode))
                        OP_MARK_RANGE:
                        begin
                            idx_next = {1'b0, cmd.page_number};
                            if ({1'b0, cmd.page_number} >= lim_now)
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        OP_ALLOC_ONE:
                        begin
                            idx_next    = start_idx;
                            status_next = ST_NO_FRAME;
                            if (owner_bad)
                            begin
                                status_next = ST_BAD_OWNER;
                                state_next  = S_FINISH;
                            end
                            else if (n_now == '0)
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        OP_ALLOC_RUN:
                        begin
                            idx_next    = '0;
                            status_next = ST_NO_FRAME;
                            if (owner_bad)
                            begin
                                status_next = ST_BAD_OWNER;
                                state_next  = S_FINISH;
                            end
                            else if ((cmd.run_length == '0) || (n_now == '0))
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        OP_FREE, OP_ADJUST, OP_SHARE:
                        begin
                            idx_next = {1'b0, cmd.page_number};
                            if ({1'b0, cmd.page_number} >= n_now)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_FINISH;
                            end
                        end
                        OP_FREE_OWNER:
                        begin
                            idx_next = '0;
                            if (n_now == '0)
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_ctl.rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_FINISH;
                case (pfa_op_t'(cmd_reg.opcode))
                    OP_MARK_RANGE:
                    begin
                        if (!rd_avail)
                        begin
                            mem_ctl.wr = 1'b1;
                            mem_wdata  = {1'b1, rd_cnt, rd_owner};
                            free_next  = free_reg + 17'd1;
                        end
                        idx_next = idx_inc;
                        if (idx_inc < limit_reg)
                        begin
                            state_next = S_READ;
                        end
                    end
                    OP_ALLOC_ONE:
                    begin
                        if (can_take)
                        begin
                            mem_ctl.wr  = 1'b1;
                            mem_wdata   = {1'b0, rd_cnt, cmd_reg.owner_id};
                            free_next   = free_dec;
                            cursor_next = (idx_inc < n_reg) ? idx_inc[15:0] : 16'd0;
                            frame_next  = idx_reg[15:0];
                            status_next = ST_OK;
                        end
                        else
                        begin
                            scan_next = scan_inc;
                            idx_next  = (idx_inc >= n_reg) ? 17'd0 : idx_inc;
                            if (scan_inc < n_reg)
                            begin
                                state_next = S_READ;
                            end
                        end
                    end
                    OP_ALLOC_RUN:
                    begin
                        idx_next = idx_inc;
                        if (can_take && (scan_inc == cmd_reg.run_length))
                        begin
                            end_next    = idx_reg;
                            idx_next    = idx_inc - cmd_reg.run_length;
                            frame_next  = 16'(idx_inc - cmd_reg.run_length);
                            status_next = ST_OK;
                            state_next  = S_RUN_WRITE;
                        end
                        else
                        begin
                            scan_next = can_take ? scan_inc : 17'd0;
                            if (idx_inc < n_reg)
                            begin
                                state_next = S_READ;
                            end
                        end
                    end
                    OP_FREE, OP_ADJUST:
                    begin
                        mem_ctl.wr = 1'b1;
                        if ((pfa_op_t'(cmd_reg.opcode) == OP_FREE) && (rd_cnt == '0))
                        begin
                            mem_wdata = {1'b1, {CB{1'b0}}, OWNER_FREED};
                            if (!rd_avail)
                            begin
                                free_next = free_reg + 17'd1;
                            end
                        end
                        else if (adj_release)
                        begin
                            mem_wdata = {1'b1, {CB{1'b0}}, cfg.free_owner_mark};
                            if (!rd_avail)
                            begin
                                free_next = free_reg + 17'd1;
                            end
                        end
                        else
                        begin
                            mem_wdata = {rd_avail, adj_cnt, rd_owner};
                        end
                    end
                    OP_SHARE:
                    begin
                        mem_ctl.wr = 1'b1;
                        if (rd_cnt == '0)
                        begin
                            mem_wdata = {rd_avail, CB'(2), rd_owner};
                        end
                        else if (rd_cnt != CNT_MAX)
                        begin
                            mem_wdata = {rd_avail, rd_cnt + CB'(1), rd_owner};
                        end
                    end
                    OP_FREE_OWNER:
                    begin
                        if ((rd_owner == cmd_reg.owner_id) && (rd_cnt == '0))
                        begin
                            mem_ctl.wr = 1'b1;
                            mem_wdata  = {1'b1, {CB{1'b0}}, cfg.free_owner_mark};
                            if (!rd_avail)
                            begin
                                free_next = free_reg + 17'd1;
                            end
                        end
                        idx_next = idx_inc;
                        if (idx_inc < n_reg)
                        begin
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RUN_WRITE:
            begin
                // Frames of the run are known free with a zero counter.
                mem_ctl.wr = 1'b1;
                mem_wdata  = {1'b0, {CB{1'b0}}, cmd_reg.owner_id};
                free_next  = free_dec;
                idx_next   = idx_inc;
                if (idx_reg == end_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_addr = idx_reg[AW-1:0];
    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_FINISH);
    assign result.frame_out   = frame_reg;
    assign result.status      = status_reg;
    assign result.free_frames = free_reg;

endmodule

### rtl/page_frame_allocator.sv
// Page frame allocator: every request is served by the table read-check step
// through one memory port; a single-frame request visits one frame, a mark
// range each frame it marks, and allocate one, allocate run and free owner
// scan up to the n frames managed, allocate run then writing its run.
// After reset the whole table is cleared with busy high.
// The result word is shown for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps

module page_frame_allocator #(
    parameter int MAX_FRAMES   = 1024,
    parameter int COUNTER_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pfa_pkg::pfa_cmd_t cmd,
    output logic              busy,
    output logic              done,
    output pfa_pkg::pfa_res_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data
);
    import pfa_pkg::*;

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int DW = 1 + COUNTER_BITS + 16;

    pfa_cfg_t      cfg_reg;
    pfa_mem_ctl_t  mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pages_in_use       <= 17'd1024;
            cfg_reg.lowest_valid_owner <= 16'sd0;
            cfg_reg.free_owner_mark    <= -16'sd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PAGES_IN_USE: cfg_reg.pages_in_use       <= cfg_data;
                CFG_LOWEST_OWNER: cfg_reg.lowest_valid_owner <= cfg_data[15:0];
                CFG_FREE_MARK:    cfg_reg.free_owner_mark    <= cfg_data[15:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    pfa_seq #(
        .MAX_FRAMES  (MAX_FRAMES),
        .COUNTER_BITS(COUNTER_BITS),
        .AW          (AW),
        .DW          (DW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .mem_rdata(mem_rdata)
    );

    pfa_table #(
        .DEPTH(MAX_FRAMES),
        .AW   (AW),
        .DW   (DW)
    ) u_table (
        .clk  (clk),
        .ctl  (mem_ctl),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

endmodule

### rtl/pfa_checker.sv
// Port-level checker for the page frame allocator and its bind statement.
// Depends on pfa_pkg and page_frame_allocator.
`timescale 1ns / 1ps

module pfa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input pfa_pkg::pfa_res_t result
);
    import pfa_pkg::*;

    // A result word only comes out while the block is still busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

    // Each result is shown for one cycle only.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    // Any failed request reports frame zero.
    a_fail_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.frame_out == 16'd0))
        else $error("failed request with nonzero frame");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);
